>>> rtl/core/rmf_pkg.sv
// Package for the recursive median filter.
// Holds register codes, fixed field widths, the sequencer state type and
// the command struct sent to the sorted cell chain. No dependencies.
package rmf_pkg;

  // Fixed widths of the configuration registers and the APB-style port.
  localparam int WLEN_W  = 6;
  localparam int ALPHA_W = 19;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Q16 fixed-point constants.
  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;

  // Reset values of the configuration registers.
  localparam logic [WLEN_W-1:0]  WLEN_RESET  = WLEN_W'(1);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(ONE_Q16);

  // Register index codes, taken from the word address.
  localparam logic REG_WLEN  = 1'b0;
  localparam logic REG_ALPHA = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_MUL,
    S_OUT
  } rmf_state_t;

  // Command to every cell of the sorted chain.
  typedef struct packed {
    logic clr;
    logic ins;
    logic del;
  } rmf_cmd_t;

endpackage

>>> rtl/core/rmf_cell.sv
// One cell of the sorted chain: holds a single sample and its occupied flag.
// Depends on rmf_pkg for the chain command struct.
module rmf_cell #(
  parameter int SW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rmf_pkg::rmf_cmd_t    cmd,
  input  logic signed [SW-1:0] key,
  input  logic signed [SW-1:0] prev_val,
  input  logic                 prev_vld,
  input  logic                 prev_gt,
  input  logic signed [SW-1:0] next_val,
  input  logic                 next_vld,
  output logic signed [SW-1:0] val,
  output logic                 vld,
  output logic                 gt
);

  logic signed [SW-1:0] val_r, val_nxt;
  logic                 vld_r, vld_nxt;
  logic                 ge;

  // An empty cell counts as larger than any key.
  assign gt = !vld_r || (val_r > key);
  assign ge = vld_r && (val_r >= key);

  // Insert shifts larger entries up by one; delete closes the gap from above.
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (cmd.ins) begin
      if (prev_gt) begin
        val_nxt = prev_val;
        vld_nxt = prev_vld;
      end else if (gt) begin
        val_nxt = key;
        vld_nxt = 1'b1;
      end
    end else if (cmd.del) begin
      if (ge) begin
        val_nxt = next_val;
        vld_nxt = next_vld;
      end
    end
  end

  // The occupied flag is control state; the value needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

>>> rtl/core/rmf_chain.sv
// Row of sorted cells that holds the window in ascending order.
// Depends on rmf_pkg and rmf_cell; also selects the entry at a given rank.
module rmf_chain #(
  parameter int SW    = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rmf_pkg::rmf_cmd_t        cmd,
  input  logic signed [SW-1:0]     key,
  input  logic [$clog2(DEPTH)-1:0] sel_idx,
  output logic signed [SW-1:0]     sel_val
);

  logic signed [SW-1:0] val [DEPTH];
  logic                 vld [DEPTH];
  logic                 gt  [DEPTH];

  // Each cell sees its left neighbor for insert and its right one for delete.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [SW-1:0] p_val, n_val;
    logic                 p_vld, p_gt, n_vld;

    if (i == 0) begin : g_first
      assign p_val = '0;
      assign p_vld = 1'b0;
      assign p_gt  = 1'b0;
    end else begin : g_mid
      assign p_val = val[i-1];
      assign p_vld = vld[i-1];
      assign p_gt  = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_val = '0;
      assign n_vld = 1'b0;
    end else begin : g_more
      assign n_val = val[i+1];
      assign n_vld = vld[i+1];
    end

    rmf_cell #(.SW(SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .key      (key),
      .prev_val (p_val),
      .prev_vld (p_vld),
      .prev_gt  (p_gt),
      .next_val (n_val),
      .next_vld (n_vld),
      .val      (val[i]),
      .vld      (vld[i]),
      .gt       (gt[i])
    );
  end

  // Rank select for the median.
  assign sel_val = val[sel_idx];

endmodule

>>> rtl/core/rmf_smooth.sv
// Exponential smoothing stage: alpha*median + (1-alpha)*last, rounded and
// saturated. Depends on rmf_pkg for the alpha width and Q16 constants.
module rmf_smooth #(
  parameter int SW = 32
) (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [SW-1:0]              med,
  input  logic signed [SW-1:0]              last,
  input  logic signed [rmf_pkg::ALPHA_W-1:0] alpha,
  output logic signed [SW-1:0]              result
);

  localparam int AW  = rmf_pkg::ALPHA_W;
  localparam int P1W = SW + AW;
  localparam int P2W = SW + AW + 1;
  localparam int ACW = SW + AW + 2;
  localparam int RW  = ACW - 16;

  logic signed [AW:0]      beta;
  logic signed [P1W-1:0]   p1_r, p1_nxt;
  logic signed [P2W-1:0]   p2_r, p2_nxt;
  logic signed [ACW-1:0]   acc;
  logic signed [RW-1:0]    rnd;
  logic                    ovf;

  // Weight of the previous result, one minus alpha in Q4.16.
  assign beta   = (AW+1)'(rmf_pkg::ONE_Q16) - {alpha[AW-1], alpha};
  assign p1_nxt = alpha * med;
  assign p2_nxt = beta * last;

  // Product registers.
  always_ff @(posedge clk) begin
    if (load) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
  end

  // Sum, round half up, drop the fraction bits.
  assign acc = ACW'(p1_r) + ACW'(p2_r) + ACW'(rmf_pkg::HALF_Q16);
  assign rnd = acc[ACW-1:16];

  // Saturate when the upper bits are not all copies of the sign.
  assign ovf = (rnd[RW-1:SW-1] != {(RW-SW+1){rnd[RW-1]}});

  always_comb begin
    if (!ovf) begin
      result = rnd[SW-1:0];
    end else if (rnd[RW-1]) begin
      result = {1'b1, {(SW-1){1'b0}}};
    end else begin
      result = {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule

>>> rtl/core/recursive_median_filter_top.sv
// Recursive median filter, top level: sorted cell chain, arrival ring memory,
// smoothing stage and configuration registers. Depends on rmf_pkg and all rmf_ modules.
// An item that gives no result leaves the sequencer idle; the next one is accepted right after.
// For an item that gives a result, the sequencer steps through chain insert at accept, median
// pick with delete of the oldest sample, multiply, then round and saturate into the output
// register, which raises out_valid; the next item is accepted only after that last step.
// A stalled full output register holds the sequencer and the input until it drains.
// Synchronous active-low reset: window length 1, alpha 1.0, window empty, last result 0.
module recursive_median_filter_top #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]    out_filtered,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rmf_pkg::ADDR_W-1:0]        paddr,
  input  logic [rmf_pkg::DATA_W-1:0]        pwdata,
  output logic [rmf_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int LW    = rmf_pkg::WLEN_W;
  localparam int AW    = rmf_pkg::ALPHA_W;
  localparam int XW    = ((PTR_W > LW) ? PTR_W : LW) + 1;

  rmf_pkg::rmf_state_t state_r, state_nxt;
  rmf_pkg::rmf_cmd_t   cmd;

  logic [LW-1:0]        wlen_r;
  logic signed [AW-1:0] alpha_r;
  logic [PTR_W-1:0]     ptr_r;
  logic [LW-1:0]        fill_r;
  logic signed [SW-1:0] last_r;
  logic signed [SW-1:0] x_r;
  logic                 hzero_r;
  logic                 first_r;
  logic signed [SW-1:0] ring_rd_r;
  logic signed [SW-1:0] med_r;
  logic                 out_valid_r;
  logic signed [SW-1:0] out_data_r;

  logic signed [SW-1:0] ring [WINDOW_MAX];

  logic                 cfg_wr;
  logic                 in_acc;
  logic                 out_load;
  logic                 smooth_load;
  logic [LW-1:0]        held;
  logic                 gives_result;
  logic [XW-1:0]        ptr_x, held_x;
  logic [PTR_W-1:0]     oldest;
  logic [PTR_W-1:0]     ptr_inc;
  logic signed [SW-1:0] chain_key;
  logic signed [SW-1:0] chain_med;
  logic [PTR_W-1:0]     med_idx;
  logic signed [SW-1:0] smooth_res;
  logic signed [SW-1:0] result;
  logic                 wlen_ok;

  // Configuration port handshake.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register readback.
  always_comb begin
    case (paddr[2])
      rmf_pkg::REG_WLEN:  prdata = rmf_pkg::DATA_W'(wlen_r);
      rmf_pkg::REG_ALPHA: prdata = rmf_pkg::DATA_W'(alpha_r);
      default:            prdata = '0;
    endcase
  end

  // A window length is taken only when odd and within the chain.
  assign wlen_ok = pwdata[0] && (32'(pwdata[LW-1:0]) <= WINDOW_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= rmf_pkg::WLEN_RESET;
      alpha_r <= rmf_pkg::ALPHA_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        rmf_pkg::REG_WLEN: begin
          if (wlen_ok) begin
            wlen_r <= pwdata[LW-1:0];
          end
        end
        rmf_pkg::REG_ALPHA: alpha_r <= pwdata[AW-1:0];
        default: ;
      endcase
    end
  end

  // Window occupancy: held samples and whether this transaction completes it.
  assign held         = (fill_r >= wlen_r) ? (wlen_r - LW'(1)) : fill_r;
  assign gives_result = ((held + LW'(1)) >= wlen_r);
  assign in_acc       = in_valid && !in_stall;

  // Ring slot of the oldest sample, modulo the ring depth.
  assign ptr_x  = XW'(ptr_r);
  assign held_x = XW'(held);
  always_comb begin
    if (ptr_x >= held_x) begin
      oldest = PTR_W'(ptr_x - held_x);
    end else begin
      oldest = PTR_W'(ptr_x + XW'(WINDOW_MAX) - held_x);
    end
  end

  assign ptr_inc = (ptr_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : (ptr_r + PTR_W'(1));

  // Arrival ring memory: write the new sample, read the oldest one.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring[ptr_r] <= in_sample;
      ring_rd_r   <= ring[oldest];
    end
  end

  // Window bookkeeping; any configuration write restarts warm-up.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (in_acc) begin
      ptr_r  <= ptr_inc;
      fill_r <= gives_result ? wlen_r : (fill_r + LW'(1));
    end
  end

  // Per-transaction payload held across the result sequence.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r     <= in_sample;
      hzero_r <= (held == '0);
      first_r <= (fill_r < wlen_r);
    end
  end

  // Sorted chain: insert on accept, delete the oldest sample afterwards.
  assign chain_key = cmd.del ? (hzero_r ? x_r : ring_rd_r) : in_sample;
  assign med_idx   = PTR_W'(wlen_r >> 1);

  rmf_chain #(.SW(SW), .DEPTH(WINDOW_MAX)) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .key     (chain_key),
    .sel_idx (med_idx),
    .sel_val (chain_med)
  );

  // Median latched from the chain before the delete lands.
  always_ff @(posedge clk) begin
    if (state_r == rmf_pkg::S_DEL) begin
      med_r <= chain_med;
    end
  end

  rmf_smooth #(.SW(SW)) u_smooth (
    .clk    (clk),
    .load   (smooth_load),
    .med    (med_r),
    .last   (last_r),
    .alpha  (alpha_r),
    .result (smooth_res)
  );

  // The first full window passes the median through unchanged.
  assign result = first_r ? med_r : smooth_res;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmf_pkg::S_IDLE: begin
        if (in_valid && gives_result) begin
          state_nxt = rmf_pkg::S_DEL;
        end
      end
      rmf_pkg::S_DEL: state_nxt = rmf_pkg::S_MUL;
      rmf_pkg::S_MUL: state_nxt = rmf_pkg::S_OUT;
      rmf_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = rmf_pkg::S_IDLE;
        end
      end
      default: state_nxt = rmf_pkg::S_IDLE;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    in_stall    = 1'b1;
    cmd.clr     = cfg_wr;
    cmd.ins     = 1'b0;
    cmd.del     = 1'b0;
    smooth_load = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      rmf_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.ins  = in_valid;
      end
      rmf_pkg::S_DEL: cmd.del = 1'b1;
      rmf_pkg::S_MUL: smooth_load = 1'b1;
      rmf_pkg::S_OUT: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Previous result, cleared on restart.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      last_r <= '0;
    end else if (out_load) begin
      last_r <= result;
    end
  end

  // Output register; it holds its transaction while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_data_r;

endmodule
